@@ rtl/overlap_best_swath_selector_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the overlap best swath selector
// Shared macros for concurrent assertions, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef OVERLAP_BEST_SWATH_SELECTOR_ASSERT_SVH
`define OVERLAP_BEST_SWATH_SELECTOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OBS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/obs_pkg.sv @@
// ----------------------------------------------------------------------------
// obs_pkg
// Types, codes and constants shared by the overlap best swath selector.
// ----------------------------------------------------------------------------
package obs_pkg;

	localparam int CELLS_DEF = 4096;

	localparam logic [1:0] OP_SCAN   = 2'd0;
	localparam logic [1:0] OP_DECIDE = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;
	localparam logic [1:0] OP_NONE   = 2'd3;

	localparam logic [2:0] CFG_CELLS      = 3'd0;
	localparam logic [2:0] CFG_SWATH_MODE = 3'd1;
	localparam logic [2:0] CFG_HAS_ANGLE  = 3'd2;
	localparam logic [2:0] CFG_HAS_RETURN = 3'd3;
	localparam logic [2:0] CFG_HAS_INTEN  = 3'd4;
	localparam logic [2:0] CFG_HAS_GPS    = 3'd5;
	localparam logic [2:0] CFG_HAS_CHAN   = 3'd6;

	localparam logic [4:0] RANK_ABSENT = 5'd16;

	typedef enum logic [1:0] {
		S_CLR,
		S_IDLE,
		S_RD,
		S_WR
	} state_t;

	typedef struct packed {
		logic [12:0] cells_in_use;
		logic        swath_mode;
		logic        has_angle;
		logic        has_return;
		logic        has_inten;
		logic        has_gps;
		logic        has_chan;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		cells_in_use: 13'd4096,
		swath_mode:   1'b0,
		has_angle:    1'b1,
		has_return:   1'b1,
		has_inten:    1'b1,
		has_gps:      1'b1,
		has_chan:     1'b1
	};

	typedef struct packed {
		logic [1:0]  op;
		logic        ovl;
		logic [15:0] cell_idx;
		logic [31:0] pidx;
		logic [8:0]  angle;
		logic [3:0]  rnum;
		logic [15:0] inten;
		logic [63:0] gps;
		logic [15:0] src;
		logic [7:0]  chan;
	} item_t;

	typedef struct packed {
		logic        valid;
		logic [7:0]  abs_angle;
		logic [4:0]  rank;
		logic [15:0] inten;
		logic [63:0] tstamp;
		logic [31:0] point;
		logic [15:0] swath;
		logic [7:0]  chan;
	} entry_t;

	typedef struct packed {
		logic in_range;
		logic old_valid;
		logic ang_ne;
		logic ang_lt;
		logic rank_ne;
		logic rank_lt;
		logic int_ne;
		logic int_gt;
		logic time_ne;
		logic time_lt;
		logic pt_lt;
		logic swath_eq;
		logic chan_eq;
	} cmp_t;

endpackage

@@ rtl/overlap_best_swath_selector.sv @@
// ----------------------------------------------------------------------------
// overlap_best_swath_selector
// Keeps the best candidate point per grid cell and decides which overlap
// points belong to the winning swath of their cell.
// ----------------------------------------------------------------------------
// An item is transferred at a clock edge with start high and busy low. The
// block then reads the cell entry, compares the keys in the next cycle and
// writes the entry back in the cycle after that. The result appears on keep,
// error, overlap_count and kept_count for exactly one cycle with done high,
// registered at the end of the write-back; the receiver cannot stall it.
// Busy stays high after each transfer until the write-back is done, so a new
// item is taken only after the read, compare and write-back of the previous
// one on the single cell memory port pair. A new item may be transferred in
// the cycle in which the previous result is shown.
// Configuration writes use cfg_valid, cfg_ready, cfg_index and cfg_data, are
// always ready and must only be issued while the block is idle.
// After reset the block sweeps the cell memory to mark every entry empty,
// one entry per cycle, with busy high. Counters, the configuration and done
// take their reset values at once.
// ----------------------------------------------------------------------------
module overlap_best_swath_selector import obs_pkg::*; #(
	parameter int CELLS = CELLS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic        in_overlap,
	input  logic [15:0] cell_index,
	input  logic [31:0] point_index,
	input  logic signed [8:0] scan_angle,
	input  logic [3:0]  return_number,
	input  logic [15:0] intensity,
	input  logic signed [63:0] gps_time,
	input  logic [15:0] source_id,
	input  logic [7:0]  scan_channel,
	output logic        done,
	output logic        keep,
	output logic        error,
	output logic [31:0] overlap_count,
	output logic [31:0] kept_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [12:0] cfg_data
);

	localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;

	state_t        state_q, state_d;
	logic [AW-1:0] clr_q;
	cfg_t          cfg_q;
	item_t         item_q;
	entry_t        rd_q, cand_q, wdata;
	cmp_t          cmp_q;
	logic          accept, we, better;
	logic [AW-1:0] waddr;
	logic          res_keep, res_err;
	logic [31:0]   ovl_tot_q, kept_tot_q, ovl_tot_d, kept_tot_d;
	logic          done_q, keep_q, error_q;

	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_CELLS:      cfg_q.cells_in_use <= cfg_data;
				CFG_SWATH_MODE: cfg_q.swath_mode   <= cfg_data[0];
				CFG_HAS_ANGLE:  cfg_q.has_angle    <= cfg_data[0];
				CFG_HAS_RETURN: cfg_q.has_return   <= cfg_data[0];
				CFG_HAS_INTEN:  cfg_q.has_inten    <= cfg_data[0];
				CFG_HAS_GPS:    cfg_q.has_gps      <= cfg_data[0];
				CFG_HAS_CHAN:   cfg_q.has_chan     <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= '{
				op:       op,
				ovl:      in_overlap,
				cell_idx: cell_index,
				pidx:     point_index,
				angle:    scan_angle,
				rnum:     return_number,
				inten:    intensity,
				gps:      gps_time,
				src:      source_id,
				chan:     scan_channel
			};
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLR:  if (clr_q == AW'(CELLS - 1)) state_d = S_IDLE;
			S_IDLE: if (start) state_d = S_RD;
			S_RD:   state_d = S_WR;
			S_WR:   state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	assign better = !cmp_q.old_valid ||
		(cmp_q.ang_ne  ? cmp_q.ang_lt  :
		 cmp_q.rank_ne ? cmp_q.rank_lt :
		 cmp_q.int_ne  ? cmp_q.int_gt  :
		 cmp_q.time_ne ? cmp_q.time_lt : cmp_q.pt_lt);

	always_comb begin
		busy  = 1'b1;
		we    = 1'b0;
		waddr = item_q.cell_idx[AW-1:0];
		wdata = cand_q;
		unique case (state_q)
			S_CLR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '0;
			end
			S_IDLE: begin
				busy = 1'b0;
			end
			S_RD: begin
			end
			S_WR: begin
				if (item_q.op == OP_SCAN) begin
					we = item_q.ovl && cmp_q.in_range && better;
				end else if (item_q.op == OP_CLEAR) begin
					we          = cmp_q.in_range;
					wdata.valid = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	obs_cell_mem #(
		.DEPTH (CELLS),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.re      (accept),
		.raddr   (cell_index[AW-1:0]),
		.rdata_q (rd_q)
	);

	obs_rank #(
		.CELLS (CELLS)
	) u_rank (
		.clk    (clk),
		.item   (item_q),
		.cfg    (cfg_q),
		.stored (rd_q),
		.cand_q (cand_q),
		.cmp_q  (cmp_q)
	);

	always_comb begin
		res_keep   = 1'b0;
		res_err    = 1'b0;
		ovl_tot_d  = ovl_tot_q;
		kept_tot_d = kept_tot_q;
		unique case (item_q.op)
			OP_SCAN: begin
				res_err = item_q.ovl && !cmp_q.in_range;
			end
			OP_DECIDE: begin
				if (!item_q.ovl) begin
					res_keep = 1'b1;
				end else begin
					if (ovl_tot_q != '1) ovl_tot_d = ovl_tot_q + 32'd1;
					if (!cmp_q.in_range) begin
						res_err = 1'b1;
					end else if (cmp_q.old_valid && cmp_q.swath_eq &&
						(!cfg_q.swath_mode || cmp_q.chan_eq)) begin
						res_keep = 1'b1;
						if (kept_tot_q != '1) kept_tot_d = kept_tot_q + 32'd1;
					end
				end
			end
			OP_CLEAR: begin
				ovl_tot_d  = '0;
				kept_tot_d = '0;
			end
			OP_NONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q     <= 1'b0;
			ovl_tot_q  <= '0;
			kept_tot_q <= '0;
		end else begin
			done_q <= (state_q == S_WR);
			if (state_q == S_WR) begin
				ovl_tot_q  <= ovl_tot_d;
				kept_tot_q <= kept_tot_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_WR) begin
			keep_q  <= res_keep;
			error_q <= res_err;
		end
	end

	assign done          = done_q;
	assign keep          = keep_q;
	assign error         = error_q;
	assign overlap_count = ovl_tot_q;
	assign kept_count    = kept_tot_q;

endmodule

@@ rtl/obs_cell_mem.sv @@
// ----------------------------------------------------------------------------
// obs_cell_mem
// One-port-write, one-port-read cell memory with registered read data.
// ----------------------------------------------------------------------------
module obs_cell_mem import obs_pkg::*; #(
	parameter int DEPTH = CELLS_DEF,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  entry_t        wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output entry_t        rdata_q
);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

endmodule

@@ rtl/obs_rank.sv @@
// ----------------------------------------------------------------------------
// obs_rank
// Builds the candidate keys of a point and compares them with the stored best.
// ----------------------------------------------------------------------------
module obs_rank import obs_pkg::*; #(
	parameter int CELLS = CELLS_DEF
) (
	input  logic   clk,
	input  item_t  item,
	input  cfg_t   cfg,
	input  entry_t stored,
	output entry_t cand_q,
	output cmp_t   cmp_q
);

	localparam logic [16:0] CELLS_W = 17'(CELLS);

	logic [9:0] mag;
	entry_t     cand;
	cmp_t       cmp;

	always_comb begin
		mag = item.angle[8] ? (10'd512 - {1'b0, item.angle}) : {1'b0, item.angle};
		cand.valid     = 1'b1;
		cand.abs_angle = !cfg.has_angle ? 8'd0 : ((mag > 10'd255) ? 8'd255 : mag[7:0]);
		cand.rank      = cfg.has_return ? {1'b0, item.rnum} : RANK_ABSENT;
		cand.inten     = cfg.has_inten ? item.inten : 16'd0;
		cand.tstamp    = cfg.has_gps ? item.gps : {32'd0, item.pidx};
		cand.point     = item.pidx;
		cand.swath     = item.src;
		cand.chan      = cfg.has_chan ? item.chan : 8'd0;
	end

	always_comb begin
		cmp.in_range  = ({1'b0, item.cell_idx} < CELLS_W) &&
			(item.cell_idx < {3'd0, cfg.cells_in_use});
		cmp.old_valid = stored.valid;
		cmp.ang_ne    = cand.abs_angle != stored.abs_angle;
		cmp.ang_lt    = cand.abs_angle < stored.abs_angle;
		cmp.rank_ne   = cand.rank != stored.rank;
		cmp.rank_lt   = cand.rank < stored.rank;
		cmp.int_ne    = cand.inten != stored.inten;
		cmp.int_gt    = cand.inten > stored.inten;
		cmp.time_ne   = cand.tstamp != stored.tstamp;
		cmp.time_lt   = {~cand.tstamp[63], cand.tstamp[62:0]} <
			{~stored.tstamp[63], stored.tstamp[62:0]};
		cmp.pt_lt     = cand.point < stored.point;
		cmp.swath_eq  = cand.swath == stored.swath;
		cmp.chan_eq   = cand.chan == stored.chan;
	end

	always_ff @(posedge clk) begin
		cand_q <= cand;
		cmp_q  <= cmp;
	end

endmodule

@@ rtl/obs_checker.sv @@
// ----------------------------------------------------------------------------
// obs_checker
// Port-level checks on the transfer, result timing and error of the selector.
// ----------------------------------------------------------------------------
`include "overlap_best_swath_selector_assert.svh"

module obs_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic keep,
	input logic error
);

	`OBS_ASSERT_NEXT(a_busy_after_xfer, clk, arst_n, start && !busy, busy, "no busy after transfer")
	`OBS_ASSERT_NEXT(a_result_latency, clk, arst_n, start && !busy, ##2 done, "result latency wrong")
	`OBS_ASSERT_SAME(a_done_idle, clk, arst_n, done, !busy, "result shown while busy")
	`OBS_ASSERT_SAME(a_err_no_keep, clk, arst_n, done && error, !keep, "error with keep set")

endmodule

bind overlap_best_swath_selector obs_checker u_obs_checker (.*);

@@ tb/overlap_best_swath_selector_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// overlap_best_swath_selector_tb
// Drives directed and random point streams through the selector under a
// range of register settings. A model in the bench keeps its own cell table
// and counters and computes the keep, error and count values for each
// transfer. Every result strobe is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module overlap_best_swath_selector_tb import obs_pkg::*;;

	typedef struct packed {
		logic        keep;
		logic        error;
		logic [31:0] overlap_count;
		logic [31:0] kept_count;
	} verdict_t;

	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                start         = 1'b0;
	logic                busy;
	logic [1:0]          op            = OP_NONE;
	logic                in_overlap    = 1'b0;
	logic [15:0]         cell_index    = '0;
	logic [31:0]         point_index   = '0;
	logic signed [8:0]   scan_angle    = '0;
	logic [3:0]          return_number = '0;
	logic [15:0]         intensity     = '0;
	logic signed [63:0]  gps_time      = '0;
	logic [15:0]         source_id     = '0;
	logic [7:0]          scan_channel  = '0;
	logic                done;
	logic                keep;
	logic                error;
	logic [31:0]         overlap_count;
	logic [31:0]         kept_count;
	logic                cfg_valid     = 1'b0;
	logic                cfg_ready;
	logic [2:0]          cfg_index     = '0;
	logic [12:0]         cfg_data      = '0;

	entry_t      best_entry [CELLS_DEF];
	cfg_t        regs_model   = CFG_RESET;
	logic [31:0] seen_overlap = '0;
	logic [31:0] seen_kept    = '0;
	verdict_t    verdict_q [$];
	int          mismatch_count = 0;
	bit          gaps_on        = 1'b1;

	overlap_best_swath_selector u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.in_overlap   (in_overlap),
		.cell_index   (cell_index),
		.point_index  (point_index),
		.scan_angle   (scan_angle),
		.return_number(return_number),
		.intensity    (intensity),
		.gps_time     (gps_time),
		.source_id    (source_id),
		.scan_channel (scan_channel),
		.done         (done),
		.keep         (keep),
		.error        (error),
		.overlap_count(overlap_count),
		.kept_count   (kept_count),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic int unsigned cell_limit();
		return (regs_model.cells_in_use < CELLS_DEF) ? regs_model.cells_in_use : CELLS_DEF;
	endfunction

	function automatic logic [31:0] bump(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	function automatic void queue_verdict(input verdict_t v);
		verdict_q.insert(verdict_q.size(), v);
	endfunction

	function automatic verdict_t select_swath(input item_t it);
		verdict_t    v;
		logic        in_rng;
		logic [7:0]  chan;
		logic [8:0]  mag;
		logic [7:0]  ang;
		logic [4:0]  rnk;
		logic [15:0] inten;
		logic [63:0] tstamp;
		logic        better;
		entry_t      e;
		v = '0;
		in_rng = it.cell_idx < cell_limit();
		chan = regs_model.has_chan ? it.chan : 8'd0;
		e = in_rng ? best_entry[it.cell_idx] : '0;
		case (it.op)
			OP_SCAN: begin
				if (it.ovl && !in_rng) begin
					v.error = 1'b1;
				end else if (it.ovl) begin
					mag = it.angle[8] ? 9'd0 - it.angle : it.angle;
					ang = !regs_model.has_angle ? 8'd0 : (mag > 9'd255) ? 8'd255 : mag[7:0];
					rnk = regs_model.has_return ? {1'b0, it.rnum} : RANK_ABSENT;
					inten = regs_model.has_inten ? it.inten : 16'd0;
					tstamp = regs_model.has_gps ? it.gps : {32'd0, it.pidx};
					if (!e.valid)
						better = 1'b1;
					else if (ang != e.abs_angle)
						better = ang < e.abs_angle;
					else if (rnk != e.rank)
						better = rnk < e.rank;
					else if (inten != e.inten)
						better = inten > e.inten;
					else if (tstamp != e.tstamp)
						better = $signed(tstamp) < $signed(e.tstamp);
					else
						better = it.pidx < e.point;
					if (better) begin
						best_entry[it.cell_idx] = '{valid: 1'b1, abs_angle: ang, rank: rnk,
							inten: inten, tstamp: tstamp, point: it.pidx, swath: it.src,
							chan: chan};
					end
				end
			end
			OP_DECIDE: begin
				if (!it.ovl) begin
					v.keep = 1'b1;
				end else begin
					seen_overlap = bump(seen_overlap);
					if (!in_rng) begin
						v.error = 1'b1;
					end else if (e.valid && e.swath == it.src &&
						(!regs_model.swath_mode || e.chan == chan)) begin
						v.keep = 1'b1;
						seen_kept = bump(seen_kept);
					end
				end
			end
			OP_CLEAR: begin
				if (in_rng)
					best_entry[it.cell_idx].valid = 1'b0;
				seen_overlap = '0;
				seen_kept = '0;
			end
			default: ;
		endcase
		v.overlap_count = seen_overlap;
		v.kept_count = seen_kept;
		return v;
	endfunction

	function automatic item_t make_point(input logic [1:0] o, input logic ovl,
		input logic [15:0] cell_no, input logic [31:0] pidx, input logic [8:0] ang,
		input logic [3:0] rn, input logic [15:0] inten, input logic [63:0] gps,
		input logic [15:0] src, input logic [7:0] chan);
		return '{op: o, ovl: ovl, cell_idx: cell_no, pidx: pidx, angle: ang, rnum: rn,
			inten: inten, gps: gps, src: src, chan: chan};
	endfunction

	function automatic logic [15:0] pick_cell();
		int unsigned lim;
		int unsigned span;
		lim = cell_limit();
		if (lim == 0)
			return 16'($urandom_range(0, 7));
		span = (lim < 4) ? lim : 4;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return 16'($urandom_range(0, span - 1));
			6, 7, 8: return 16'(lim - 1 - $urandom_range(0, span - 1));
			default: return $urandom_range(0, 1) ? 16'(lim) : 16'($urandom);
		endcase
	endfunction

	// Most items are well-formed traffic over a few cells and swaths so that
	// ranking ties and swath matches occur often; the rest are raw noise.
	function automatic item_t random_item();
		item_t       it;
		int unsigned roll;
		it.op = 2'($urandom);
		it.ovl = 1'($urandom);
		it.cell_idx = 16'($urandom);
		it.pidx = $urandom;
		it.angle = 9'($urandom);
		it.rnum = 4'($urandom);
		it.inten = 16'($urandom);
		it.gps = {$urandom, $urandom};
		it.src = 16'($urandom);
		it.chan = 8'($urandom);
		if ($urandom_range(0, 99) >= 15) begin
			roll = $urandom_range(0, 99);
			it.op = (roll < 46) ? OP_SCAN : (roll < 92) ? OP_DECIDE :
				(roll < 97) ? OP_CLEAR : OP_NONE;
			it.ovl = $urandom_range(0, 99) < 85;
			it.cell_idx = pick_cell();
			it.src = 16'($urandom_range(0, 3));
			it.chan = 8'($urandom_range(0, 3));
			it.pidx = $urandom_range(0, 7);
			it.inten = 16'($urandom_range(0, 2)) << 14;
			if ($urandom_range(0, 9) != 0)
				it.angle = 9'($urandom_range(0, 6)) - 9'd3;
			if ($urandom_range(0, 7) != 0)
				it.rnum = 4'($urandom_range(1, 3));
			if ($urandom_range(0, 7) != 0)
				it.gps = 64'($urandom_range(0, 4)) - 64'd2;
		end
		return it;
	endfunction

	function automatic cfg_t random_setting(input logic [12:0] cells);
		cfg_t s;
		s.cells_in_use = cells;
		s.swath_mode = 1'($urandom);
		s.has_angle = 1'($urandom);
		s.has_return = 1'($urandom);
		s.has_inten = 1'($urandom);
		s.has_gps = 1'($urandom);
		s.has_chan = 1'($urandom);
		return s;
	endfunction

	task automatic send_item(input item_t it);
		if (gaps_on && $urandom_range(0, 99) < 15) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		start <= 1'b1;
		op <= it.op;
		in_overlap <= it.ovl;
		cell_index <= it.cell_idx;
		point_index <= it.pidx;
		scan_angle <= it.angle;
		return_number <= it.rnum;
		intensity <= it.inten;
		gps_time <= it.gps;
		source_id <= it.src;
		scan_channel <= it.chan;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		queue_verdict(select_swath(it));
	endtask

	task automatic send_random(input int n);
		repeat (n)
			send_item(random_item());
	endtask

	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (verdict_q.size() != 0)
			@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [12:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_CELLS:      regs_model.cells_in_use = val;
			CFG_SWATH_MODE: regs_model.swath_mode = val[0];
			CFG_HAS_ANGLE:  regs_model.has_angle = val[0];
			CFG_HAS_RETURN: regs_model.has_return = val[0];
			CFG_HAS_INTEN:  regs_model.has_inten = val[0];
			CFG_HAS_GPS:    regs_model.has_gps = val[0];
			CFG_HAS_CHAN:   regs_model.has_chan = val[0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_setting(input cfg_t s);
		settle();
		write_reg(CFG_CELLS, s.cells_in_use);
		write_reg(CFG_SWATH_MODE, {12'($urandom), s.swath_mode});
		write_reg(CFG_HAS_ANGLE, {12'($urandom), s.has_angle});
		write_reg(CFG_HAS_RETURN, {12'($urandom), s.has_return});
		write_reg(CFG_HAS_INTEN, {12'($urandom), s.has_inten});
		write_reg(CFG_HAS_GPS, {12'($urandom), s.has_gps});
		write_reg(CFG_HAS_CHAN, {12'($urandom), s.has_chan});
	endtask

	task automatic test_field_extremes();
		send_item(make_point(OP_SCAN, 1'b1, 16'd0, 32'hFFFF_FFFF, 9'h100, 4'd15,
			16'hFFFF, 64'h8000_0000_0000_0000, 16'hFFFF, 8'hFF));
		send_item(make_point(OP_SCAN, 1'b1, 16'd0, 32'd0, 9'd0, 4'd0, 16'd0,
			64'h7FFF_FFFF_FFFF_FFFF, 16'd0, 8'd0));
		send_item(make_point(OP_SCAN, 1'b1, 16'd4095, 32'hFFFF_FFFF, 9'h0FF, 4'd15,
			16'hFFFF, 64'h8000_0000_0000_0000, 16'hFFFF, 8'hFF));
		send_item(make_point(OP_DECIDE, 1'b1, 16'd0, 32'd1, 9'd0, 4'd0, 16'd0, 64'd0,
			16'd0, 8'd0));
		send_item(make_point(OP_DECIDE, 1'b1, 16'd4095, 32'd2, 9'd0, 4'd0, 16'd0, 64'd0,
			16'hFFFF, 8'd0));
		send_item(make_point(OP_SCAN, 1'b1, 16'd4096, 32'd3, 9'd0, 4'd0, 16'd0, 64'd0,
			16'd0, 8'd0));
		send_item(make_point(OP_DECIDE, 1'b1, 16'hFFFF, 32'd4, 9'd0, 4'd0, 16'd0, 64'd0,
			16'd0, 8'd0));
		send_item(make_point(OP_SCAN, 1'b0, 16'hFFFF, 32'd5, 9'd0, 4'd0, 16'd0, 64'd0,
			16'd0, 8'd0));
		send_item(make_point(OP_DECIDE, 1'b0, 16'hFFFF, 32'd6, 9'd0, 4'd0, 16'd0, 64'd0,
			16'd0, 8'd0));
		send_item(make_point(OP_NONE, 1'b1, 16'd0, 32'd7, 9'd0, 4'd0, 16'd0, 64'd0,
			16'd0, 8'd0));
		send_item(make_point(OP_DECIDE, 1'b1, 16'd5, 32'd8, 9'd0, 4'd0, 16'd0, 64'd0,
			16'd0, 8'd0));
	endtask

	// After a first fill and a full tie that must lose, each scan beats the
	// stored one on exactly one key, up the ranking from point index to angle.
	task automatic test_ranking_order();
		send_item(make_point(OP_SCAN, 1'b1, 16'd7, 32'd100, 9'd5, 4'd2, 16'd50,
			64'd1000, 16'd1, 8'd0));
		send_item(make_point(OP_SCAN, 1'b1, 16'd7, 32'd100, -9'sd5, 4'd2, 16'd50,
			64'd1000, 16'd2, 8'd0));
		send_item(make_point(OP_SCAN, 1'b1, 16'd7, 32'd99, 9'd5, 4'd2, 16'd50,
			64'd1000, 16'd3, 8'd0));
		send_item(make_point(OP_SCAN, 1'b1, 16'd7, 32'd200, 9'd5, 4'd2, 16'd50,
			-64'sd1, 16'd4, 8'd0));
		send_item(make_point(OP_SCAN, 1'b1, 16'd7, 32'd200, 9'd5, 4'd2, 16'd60,
			64'd5000, 16'd5, 8'd0));
		send_item(make_point(OP_SCAN, 1'b1, 16'd7, 32'd200, 9'd5, 4'd1, 16'd0,
			64'd5000, 16'd6, 8'd0));
		send_item(make_point(OP_SCAN, 1'b1, 16'd7, 32'd300, -9'sd4, 4'd15, 16'd0,
			64'd9000, 16'd7, 8'd0));
		send_item(make_point(OP_DECIDE, 1'b1, 16'd7, 32'd1, 9'd0, 4'd0, 16'd0, 64'd0,
			16'd7, 8'd9));
		send_item(make_point(OP_DECIDE, 1'b1, 16'd7, 32'd2, 9'd0, 4'd0, 16'd0, 64'd0,
			16'd6, 8'd0));
	endtask

	task automatic test_clear_and_range();
		send_item(make_point(OP_CLEAR, 1'b1, 16'd7, 32'd0, 9'd0, 4'd0, 16'd0, 64'd0,
			16'd0, 8'd0));
		send_item(make_point(OP_DECIDE, 1'b1, 16'd7, 32'd1, 9'd0, 4'd0, 16'd0, 64'd0,
			16'd7, 8'd0));
		send_item(make_point(OP_CLEAR, 1'b1, 16'hFFFF, 32'd0, 9'd0, 4'd0, 16'd0, 64'd0,
			16'd0, 8'd0));
	endtask

	task automatic test_settings_sweep();
		cfg_t s;
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: s = '{cells_in_use: 13'd1, swath_mode: 1'b1, default: 1'b0};
				1: s = '{cells_in_use: 13'd4096, default: 1'b1};
				2: s = random_setting(13'h1FFF);
				3: s = random_setting(13'd0);
				7: s = random_setting(13'($urandom_range(1, 4096)));
				default: s = random_setting(13'($urandom_range(1, 24)));
			endcase
			apply_setting(s);
			send_random(100);
		end
	endtask

	task automatic test_unbroken_stream();
		apply_setting(random_setting(13'($urandom_range(1, 16))));
		gaps_on = 1'b0;
		send_random(300);
		gaps_on = 1'b1;
	endtask

	task automatic report(input string what, input logic [31:0] want,
		input logic [31:0] got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, what, want, got);
	endtask

	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && done) begin
			if (verdict_q.size() == 0) begin
				report("result without a pending transfer, keep", 32'd0, 32'(keep));
			end else begin
				want = verdict_q.pop_front();
				if (want.keep !== keep)
					report("keep", 32'(want.keep), 32'(keep));
				if (want.error !== error)
					report("error", 32'(want.error), 32'(error));
				if (want.overlap_count !== overlap_count)
					report("overlap_count", want.overlap_count, overlap_count);
				if (want.kept_count !== kept_count)
					report("kept_count", want.kept_count, kept_count);
			end
		end
	end

	initial begin
		foreach (best_entry[i])
			best_entry[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_field_extremes();
		test_ranking_order();
		test_clear_and_range();
		test_settings_sweep();
		test_unbroken_stream();
		start <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && verdict_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
